/* hw/rtl/rsitp_pkg.sv */
// ----------------------------------------------------------------------------
// rsitp_pkg: shared types and constants of the return stack / indirect target predictor
// Holds the request codes, the branch kinds, the default table sizes and the
// control bundles that the top level sends to each storage unit.
// ----------------------------------------------------------------------------
package rsitp_pkg;

	// Default sizes of the three tables.
	localparam int STACK_DEPTH_DEF       = 1536;
	localparam int INDIRECT_ENTRIES_DEF  = 4096;
	localparam int CALL_SIZE_ENTRIES_DEF = 1024;

	// Field widths fixed by the request and result formats.
	localparam int ADDR_W      = 64;
	localparam int CALL_SIZE_W = 4;

	// Call size learning.
	localparam logic [ADDR_W-1:0]      MAX_CALL_DISTANCE = 64'd10;
	localparam logic [CALL_SIZE_W-1:0] RESET_CALL_SIZE   = 4'd4;

	typedef enum logic {
		OP_PREDICT = 1'b0,
		OP_UPDATE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_JUMP          = 3'd0,
		KIND_INDIRECT      = 3'd1,
		KIND_CONDITIONAL   = 3'd2,
		KIND_CALL          = 3'd3,
		KIND_INDIRECT_CALL = 3'd4,
		KIND_RETURN        = 3'd5,
		KIND_OTHER         = 3'd6
	} kind_t;

	// Return stack: en reads the top, push writes the address above it,
	// pop clears the top and steps back.
	typedef struct packed {
		logic en;
		logic push;
		logic pop;
	} stk_ctl_t;

	// Indirect target table and conditional history.
	typedef struct packed {
		logic en;
		logic write;
		logic shift;
		logic taken;
	} itt_ctl_t;

	// Call size table: one read or one write per request.
	typedef struct packed {
		logic read;
		logic write;
	} csz_ctl_t;

endpackage

/* hw/rtl/rsitp_stack.sv */
// ----------------------------------------------------------------------------
// rsitp_stack: circular return address stack
// Keeps the stack pointer and the stack memory; reads the top on every
// accepted request and applies at most one push or pop write.
// ----------------------------------------------------------------------------
module rsitp_stack #(
	parameter int STACK_DEPTH = rsitp_pkg::STACK_DEPTH_DEF,
	parameter int CLR_W       = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic [CLR_W-1:0]                clear_idx,
	input  rsitp_pkg::stk_ctl_t             ctl,
	input  logic [rsitp_pkg::ADDR_W-1:0]    push_addr,
	output logic [rsitp_pkg::ADDR_W-1:0]    top_data
);

	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [rsitp_pkg::ADDR_W-1:0] mem [STACK_DEPTH];
	logic [SW-1:0]                ptr_q;
	logic [SW:0]                  ptr_inc;
	logic [SW-1:0]                ptr_push;
	logic [SW-1:0]                ptr_pop;

	always_comb begin
		ptr_inc  = {1'b0, ptr_q} + (SW+1)'(1);
		ptr_push = (ptr_inc >= (SW+1)'(STACK_DEPTH)) ? '0 : ptr_inc[SW-1:0];
		ptr_pop  = (ptr_q == '0) ? SW'(STACK_DEPTH - 1) : ptr_q - SW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.push) begin
			ptr_q <= ptr_push;
		end else if (ctl.pop) begin
			ptr_q <= ptr_pop;
		end
	end

	// The read returns the entry as it stood before this edge's write.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			top_data <= mem[ptr_q];
		end
		if (clear && (32'(clear_idx) < STACK_DEPTH)) begin
			mem[clear_idx[SW-1:0]] <= '0;
		end else if (ctl.push) begin
			mem[ptr_push] <= push_addr;
		end else if (ctl.pop) begin
			mem[ptr_q] <= '0;
		end
	end

endmodule

/* hw/rtl/rsitp_itt.sv */
// ----------------------------------------------------------------------------
// rsitp_itt: indirect target table with conditional history
// Hashes the branch address with the taken history, reads or writes the
// target memory, and shifts resolved conditional outcomes into the history.
// ----------------------------------------------------------------------------
module rsitp_itt #(
	parameter int INDIRECT_ENTRIES = rsitp_pkg::INDIRECT_ENTRIES_DEF,
	parameter int CLR_W            = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic [CLR_W-1:0]                clear_idx,
	input  rsitp_pkg::itt_ctl_t             ctl,
	input  logic [rsitp_pkg::ADDR_W-1:0]    addr,
	input  logic [rsitp_pkg::ADDR_W-1:0]    wdata,
	output logic [rsitp_pkg::ADDR_W-1:0]    rdata
);

	localparam int IW = $clog2(INDIRECT_ENTRIES);

	logic [rsitp_pkg::ADDR_W-1:0] mem [INDIRECT_ENTRIES];
	// Only the history bits that reach the index are kept.
	logic [IW-1:0]                hist_q;
	logic [IW-1:0]                idx;

	assign idx = (addr[IW+1:2] ^ hist_q) & IW'(INDIRECT_ENTRIES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.shift) begin
			hist_q <= {hist_q[IW-2:0], ctl.taken};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rdata <= mem[idx];
		end
		if (clear && (32'(clear_idx) < INDIRECT_ENTRIES)) begin
			mem[clear_idx[IW-1:0]] <= '0;
		end else if (ctl.write) begin
			mem[idx] <= wdata;
		end
	end

endmodule

/* hw/rtl/rsitp_csz.sv */
// ----------------------------------------------------------------------------
// rsitp_csz: learned call instruction sizes
// Indexed by the low bits of a call address; read for return predictions
// and written when a resolved return lies close to its call.
// ----------------------------------------------------------------------------
module rsitp_csz #(
	parameter int CALL_SIZE_ENTRIES = rsitp_pkg::CALL_SIZE_ENTRIES_DEF,
	parameter int CLR_W             = 12
) (
	input  logic                                 clk,
	input  logic                                 clear,
	input  logic [CLR_W-1:0]                     clear_idx,
	input  rsitp_pkg::csz_ctl_t                  ctl,
	input  logic [rsitp_pkg::ADDR_W-1:0]         addr,
	input  logic [rsitp_pkg::CALL_SIZE_W-1:0]    wdata,
	output logic [rsitp_pkg::CALL_SIZE_W-1:0]    rdata
);

	localparam int CW = $clog2(CALL_SIZE_ENTRIES);

	logic [rsitp_pkg::CALL_SIZE_W-1:0] mem [CALL_SIZE_ENTRIES];
	logic [CW-1:0]                     idx;

	assign idx = addr[CW-1:0] & CW'(CALL_SIZE_ENTRIES - 1);

	always_ff @(posedge clk) begin
		if (ctl.read) begin
			rdata <= mem[idx];
		end
		if (clear && (32'(clear_idx) < CALL_SIZE_ENTRIES)) begin
			mem[clear_idx[CW-1:0]] <= rsitp_pkg::RESET_CALL_SIZE;
		end else if (ctl.write) begin
			mem[idx] <= wdata;
		end
	end

endmodule

/* hw/rtl/return_stack_indirect_target_predictor.sv */
// ----------------------------------------------------------------------------
// return_stack_indirect_target_predictor: return and indirect target predictor
// Predicts returns from a circular return stack plus a learned call size and
// indirect branches from a history-hashed target table; learns from updates.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Group          Contents
//  --------  ---  -------------  --------------------------------------------
//  request   in   s_t*           prediction request or resolved update
//  result    out  m_t*           predicted target, taken, handled flag
//
// Every accepted request gives exactly one result, in order, and one request
// can be taken per cycle. Three register stages lie between request and result
// (stack and table read, call size read, result register). The first loads on
// the accepting edge. The call size read has a stage of its own, since its
// address is read from the return stack. After reset a clearing pass over the
// max(STACK_DEPTH, INDIRECT_ENTRIES, CALL_SIZE_ENTRIES) indices (4096 at the
// default sizes) initializes the tables; s_tready stays low until it finishes.
// A stalled result only holds back the stages behind it as far as they are
// full, so requests are still taken while bubbles remain in the pipeline.
module return_stack_indirect_target_predictor #(
	parameter int STACK_DEPTH       = rsitp_pkg::STACK_DEPTH_DEF,
	parameter int INDIRECT_ENTRIES  = rsitp_pkg::INDIRECT_ENTRIES_DEF,
	parameter int CALL_SIZE_ENTRIES = rsitp_pkg::CALL_SIZE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Request channel.
	input  logic         s_tvalid,
	output logic         s_tready,
	// branch_address [63:0], resolved_target [127:64], resolved_taken [128],
	// zero fill [135:129]
	input  logic [135:0] s_tdata,
	// operation [0], branch_kind [3:1]
	input  logic [3:0]   s_tuser,
	// Result channel.
	output logic         m_tvalid,
	input  logic         m_tready,
	// predicted_target [63:0], predicted_taken [64], zero fill [71:65]
	output logic [71:0]  m_tdata,
	// handled [0]
	output logic [0:0]   m_tuser
);

	// The clearing pass covers the largest table.
	localparam int MAX_SI     = (STACK_DEPTH > INDIRECT_ENTRIES) ? STACK_DEPTH
	                                                             : INDIRECT_ENTRIES;
	localparam int CLEAR_LEN  = (MAX_SI > CALL_SIZE_ENTRIES) ? MAX_SI : CALL_SIZE_ENTRIES;
	localparam int CLR_W      = $clog2(CLEAR_LEN);
	localparam int AW         = rsitp_pkg::ADDR_W;
	localparam int SZW        = rsitp_pkg::CALL_SIZE_W;

	// Clearing pass after reset.
	logic             clearing_q;
	logic [CLR_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + CLR_W'(1);
			if (clr_idx_q == CLR_W'(CLEAR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Request fields.
	rsitp_pkg::op_t   op_in;
	rsitp_pkg::kind_t kind_in;
	logic [AW-1:0]    addr_in;
	logic [AW-1:0]    target_in;
	logic             taken_in;

	assign op_in     = rsitp_pkg::op_t'(s_tuser[0]);
	assign kind_in   = rsitp_pkg::kind_t'(s_tuser[3:1]);
	assign addr_in   = s_tdata[63:0];
	assign target_in = s_tdata[127:64];
	assign taken_in  = s_tdata[128];

	// Stage handshakes: a stage moves on when the one ahead is empty or moving.
	logic valid_s1, valid_s2, out_valid_q;
	logic en_out, en_s2, en_s1, accept;

	assign en_out   = !out_valid_q || m_tready;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1 && !clearing_q;
	assign accept   = s_tvalid && s_tready;

	// Request decode.
	logic push_in, pop_in, ret_pred_in, ind_pred_in, ind_wr_in, shift_in;

	always_comb begin
		push_in     = 1'b0;
		pop_in      = 1'b0;
		ret_pred_in = 1'b0;
		ind_pred_in = 1'b0;
		ind_wr_in   = 1'b0;
		shift_in    = 1'b0;
		if (op_in == rsitp_pkg::OP_PREDICT) begin
			unique case (kind_in) inside
				rsitp_pkg::KIND_CALL: begin
					push_in = 1'b1;
				end
				rsitp_pkg::KIND_INDIRECT_CALL: begin
					push_in     = 1'b1;
					ind_pred_in = 1'b1;
				end
				rsitp_pkg::KIND_INDIRECT: begin
					ind_pred_in = 1'b1;
				end
				rsitp_pkg::KIND_RETURN: begin
					ret_pred_in = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (kind_in) inside
				rsitp_pkg::KIND_INDIRECT, rsitp_pkg::KIND_INDIRECT_CALL: begin
					ind_wr_in = 1'b1;
				end
				rsitp_pkg::KIND_CONDITIONAL: begin
					shift_in = 1'b1;
				end
				rsitp_pkg::KIND_RETURN: begin
					pop_in = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Stack and indirect table are read and written on the accepting edge,
	// so each request sees every earlier request's writes.
	rsitp_pkg::stk_ctl_t stk_ctl;
	rsitp_pkg::itt_ctl_t itt_ctl;
	logic [AW-1:0]       stk_top;
	logic [AW-1:0]       itt_data;

	always_comb begin
		stk_ctl.en    = accept;
		stk_ctl.push  = accept && push_in;
		stk_ctl.pop   = accept && pop_in;
		itt_ctl.en    = accept;
		itt_ctl.write = accept && ind_wr_in;
		itt_ctl.shift = accept && shift_in;
		itt_ctl.taken = taken_in;
	end

	rsitp_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.CLR_W       (CLR_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clearing_q),
		.clear_idx (clr_idx_q),
		.ctl       (stk_ctl),
		.push_addr (addr_in),
		.top_data  (stk_top)
	);

	rsitp_itt #(
		.INDIRECT_ENTRIES (INDIRECT_ENTRIES),
		.CLR_W            (CLR_W)
	) u_itt (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clearing_q),
		.clear_idx (clr_idx_q),
		.ctl       (itt_ctl),
		.addr      (addr_in),
		.wdata     (target_in),
		.rdata     (itt_data)
	);

	// Stage 1 payload.
	logic          ret_pred_s1, hit_s1, ret_upd_s1;
	logic [AW-1:0] target_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ret_pred_s1 <= ret_pred_in;
			hit_s1      <= ret_pred_in || ind_pred_in;
			ret_upd_s1  <= pop_in;
			target_s1   <= target_in;
		end
	end

	// Distance between the popped call address and the return target; a
	// close pair teaches the call size of that call address.
	logic          call_above;
	logic [AW-1:0] call_dist;
	logic          dist_small;

	always_comb begin
		call_above = stk_top > target_s1;
		call_dist  = call_above ? (stk_top - target_s1) : (target_s1 - stk_top);
		dist_small = call_dist <= rsitp_pkg::MAX_CALL_DISTANCE;
	end

	// The call size table is read and written in one place, as stage 1
	// moves on, which keeps its accesses in request order.
	rsitp_pkg::csz_ctl_t csz_ctl;
	logic [SZW-1:0]      csz_data;

	always_comb begin
		csz_ctl.read  = en_s2 && valid_s1 && ret_pred_s1;
		csz_ctl.write = en_s2 && valid_s1 && ret_upd_s1 && dist_small;
	end

	rsitp_csz #(
		.CALL_SIZE_ENTRIES (CALL_SIZE_ENTRIES),
		.CLR_W             (CLR_W)
	) u_csz (
		.clk       (clk),
		.clear     (clearing_q),
		.clear_idx (clr_idx_q),
		.ctl       (csz_ctl),
		.addr      (stk_top),
		.wdata     (call_dist[SZW-1:0]),
		.rdata     (csz_data)
	);

	// Stage 2 payload: the memory read data of stage 1 is copied here
	// because the memories read again on the next accepted request.
	logic          ret_s2, hit_s2;
	logic [AW-1:0] top_s2, itt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			ret_s2 <= ret_pred_s1;
			hit_s2 <= hit_s1;
			top_s2 <= stk_top;
			itt_s2 <= itt_data;
		end
	end

	// Return targets wrap modulo 2^64.
	logic [AW-1:0] pred_s2;

	always_comb begin
		if (!hit_s2) begin
			pred_s2 = '0;
		end else if (ret_s2) begin
			pred_s2 = top_s2 + AW'(csz_data);
		end else begin
			pred_s2 = itt_s2;
		end
	end

	// Result register.
	logic [AW-1:0] out_target_q;
	logic          out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			out_target_q <= pred_s2;
			out_hit_q    <= hit_s2;
		end
	end

	// Handled predictions are always predicted taken.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_hit_q, out_target_q};
	assign m_tuser  = out_hit_q;

endmodule

/* sim/return_stack_indirect_target_predictor_checker.sv */
// ----------------------------------------------------------------------------
// return_stack_indirect_target_predictor_checker: result checker
// Watches the request and result channels, keeps its own copy of the return
// stack, the indirect target table, the branch history and the call sizes,
// and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module return_stack_indirect_target_predictor_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic [3:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           mismatches,
	output int           pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH       = rsitp_pkg::STACK_DEPTH_DEF;
	localparam int INDIRECT_ENTRIES  = rsitp_pkg::INDIRECT_ENTRIES_DEF;
	localparam int CALL_SIZE_ENTRIES = rsitp_pkg::CALL_SIZE_ENTRIES_DEF;

	typedef struct packed {
		rsitp_pkg::op_t               op;
		logic [rsitp_pkg::ADDR_W-1:0] addr;
		logic [2:0]                   kind;
		logic [rsitp_pkg::ADDR_W-1:0] target;
		logic                         taken;
	} branch_request_t;

	typedef struct packed {
		logic [rsitp_pkg::ADDR_W-1:0] target;
		logic                         taken;
		logic                         handled;
	} branch_prediction_t;

	logic [rsitp_pkg::ADDR_W-1:0]      call_stack [STACK_DEPTH];
	int unsigned                       stack_top;
	logic [rsitp_pkg::ADDR_W-1:0]      target_table [INDIRECT_ENTRIES];
	logic [15:0]                       branch_history;
	logic [rsitp_pkg::CALL_SIZE_W-1:0] call_size_table [CALL_SIZE_ENTRIES];

	branch_prediction_t expected_results [$];
	branch_prediction_t wanted;
	branch_request_t    request;
	int                 failure_count = 0;

	function automatic int unsigned indirect_slot(input logic [rsitp_pkg::ADDR_W-1:0] addr);
		return int'(((addr >> 2) ^ {48'b0, branch_history}) & 64'(INDIRECT_ENTRIES - 1));
	endfunction

	function automatic int unsigned size_slot(input logic [rsitp_pkg::ADDR_W-1:0] addr);
		return int'(addr & 64'(CALL_SIZE_ENTRIES - 1));
	endfunction

	// Applies one request to the tables and returns the prediction it yields.
	function automatic branch_prediction_t predict_branch(input branch_request_t req);
		branch_prediction_t           res;
		logic [rsitp_pkg::ADDR_W-1:0] top_addr;
		logic [rsitp_pkg::ADDR_W-1:0] distance;
		res = '0;
		if (req.op == rsitp_pkg::OP_PREDICT) begin
			if (req.kind == rsitp_pkg::KIND_CALL ||
			    req.kind == rsitp_pkg::KIND_INDIRECT_CALL) begin
				stack_top = (stack_top + 1 >= STACK_DEPTH) ? 0 : stack_top + 1;
				call_stack[stack_top] = req.addr;
			end
			if (req.kind == rsitp_pkg::KIND_RETURN) begin
				top_addr = call_stack[stack_top];
				res.target  = top_addr + 64'(call_size_table[size_slot(top_addr)]);
				res.taken   = 1'b1;
				res.handled = 1'b1;
			end else if (req.kind == rsitp_pkg::KIND_INDIRECT ||
			             req.kind == rsitp_pkg::KIND_INDIRECT_CALL) begin
				res.target  = target_table[indirect_slot(req.addr)];
				res.taken   = 1'b1;
				res.handled = 1'b1;
			end
		end else begin
			if (req.kind == rsitp_pkg::KIND_INDIRECT ||
			    req.kind == rsitp_pkg::KIND_INDIRECT_CALL) begin
				target_table[indirect_slot(req.addr)] = req.target;
			end else if (req.kind == rsitp_pkg::KIND_CONDITIONAL) begin
				branch_history = {branch_history[14:0], req.taken};
			end else if (req.kind == rsitp_pkg::KIND_RETURN) begin
				// Pop clears the top entry and steps back, wrapping below zero.
				top_addr = call_stack[stack_top];
				call_stack[stack_top] = '0;
				stack_top = (stack_top == 0) ? STACK_DEPTH - 1 : stack_top - 1;
				distance = (top_addr > req.target) ? top_addr - req.target
				                                   : req.target - top_addr;
				if (distance <= rsitp_pkg::MAX_CALL_DISTANCE)
					call_size_table[size_slot(top_addr)] =
						distance[rsitp_pkg::CALL_SIZE_W-1:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		failure_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++)
				call_stack[i] = '0;
			for (int i = 0; i < INDIRECT_ENTRIES; i++)
				target_table[i] = '0;
			for (int i = 0; i < CALL_SIZE_ENTRIES; i++)
				call_size_table[i] = rsitp_pkg::RESET_CALL_SIZE;
			stack_top      = 0;
			branch_history = '0;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h/%b with no request pending",
						m_tdata[63:0], m_tuser[0]));
				end else begin
					wanted = expected_results.pop_front();
					if (m_tdata[63:0] !== wanted.target)
						report_mismatch($sformatf("predicted_target %h, expected %h",
							m_tdata[63:0], wanted.target));
					if (m_tdata[64] !== wanted.taken)
						report_mismatch($sformatf("predicted_taken %b, expected %b",
							m_tdata[64], wanted.taken));
					if (m_tuser[0] !== wanted.handled)
						report_mismatch($sformatf("handled %b, expected %b",
							m_tuser[0], wanted.handled));
				end
			end
			if (s_tvalid && s_tready) begin
				request.op     = rsitp_pkg::op_t'(s_tuser[0]);
				request.kind   = s_tuser[3:1];
				request.addr   = s_tdata[63:0];
				request.target = s_tdata[127:64];
				request.taken  = s_tdata[128];
				expected_results.insert(expected_results.size(), predict_branch(request));
			end
		end
		// Published with a nonblocking update so the stimulus side always sees
		// the totals as of the previous edge.
		pending_results <= expected_results.size();
		mismatches      <= failure_count;
	end

endmodule

/* sim/return_stack_indirect_target_predictor_test.sv */
// ----------------------------------------------------------------------------
// return_stack_indirect_target_predictor_test: regression for the predictor
// Drives a directed set of requests for stack wrap, call size learning and
// the indirect table, then call/return and indirect sequences with random
// content plus noise, with random stalls on both channels. The checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module return_stack_indirect_target_predictor_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Kind code seven is not one of the named kinds but fits in the field; the
	// block must treat it like "other".
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	localparam int RANDOM_ITEMS    = 950;
	localparam int POOL_SIZE       = 24;
	localparam int IDLE_PERCENT    = 12;
	localparam int HOLDOFF_CYCLES  = 400;
	localparam int DRAIN_CYCLES    = 12;
	// Cycles with no handshake on either side before the run is declared
	// hung. Covers the table clearing pass after reset and the long result
	// hold-off with a wide margin.
	localparam int WATCHDOG_LIMIT  = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic [3:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic [0:0]   m_tuser;

	int mismatches;
	int pending_results;

	// Shared between the request driver and the result receiver.
	bit quiet_phase;
	bit holdoff_req;

	int                           sent_items;
	logic [rsitp_pkg::ADDR_W-1:0] address_pool [POOL_SIZE];
	// Addresses of calls the request stream has opened and not yet returned
	// from, so that return updates can be made to match their call.
	logic [rsitp_pkg::ADDR_W-1:0] open_calls [$];

	return_stack_indirect_target_predictor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	return_stack_indirect_target_predictor_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [rsitp_pkg::ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Offers one request and returns at the edge where it is accepted. The
	// valid is left high, so a following request goes out back to back
	// unless the next call decides to idle first.
	task automatic send_request(input rsitp_pkg::op_t op,
	                            input logic [rsitp_pkg::ADDR_W-1:0] addr,
	                            input logic [2:0] kind,
	                            input logic [rsitp_pkg::ADDR_W-1:0] target,
	                            input logic taken);
		while (!quiet_phase && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, taken, target, addr};
		s_tuser  <= {kind, op};
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	// Waits until the checker has no result outstanding. It waits on the clock
	// before its first look, so a request accepted at this edge is already counted.
	task automatic wait_for_drain();
		do @(posedge clk); while (pending_results != 0);
	endtask

	// Mostly well-formed branch sequences from a small address pool, so call
	// sizes and indirect entries are learned and then hit; the rest is noise.
	task automatic run_random(input int count);
		int                           stop_at;
		int                           pick;
		logic [rsitp_pkg::ADDR_W-1:0] addr;
		logic [rsitp_pkg::ADDR_W-1:0] target;
		logic [3:0]                   gap;
		logic [2:0]                   kind;
		rsitp_pkg::op_t               op;
		stop_at = sent_items + count;
		while (sent_items < stop_at) begin
			pick = $urandom_range(99);
			addr = address_pool[$urandom_range(POOL_SIZE - 1)];
			if (pick < 28) begin
				// A call is fetched; often its return is looked up right away.
				kind = ($urandom_range(1) != 0) ? rsitp_pkg::KIND_CALL
				                                : rsitp_pkg::KIND_INDIRECT_CALL;
				send_request(rsitp_pkg::OP_PREDICT, addr, kind, rand64(),
					1'($urandom_range(1)));
				open_calls.insert(open_calls.size(), addr);
				if ($urandom_range(1) != 0)
					send_request(rsitp_pkg::OP_PREDICT, rand64(), rsitp_pkg::KIND_RETURN,
						rand64(), 1'($urandom_range(1)));
			end else if (pick < 52) begin
				// A return is fetched and then resolved. Distances around the
				// learning limit of ten, on both sides of the call address.
				if (open_calls.size() != 0)
					addr = open_calls.pop_back();
				gap    = 4'($urandom_range(12));
				target = ($urandom_range(3) == 0) ? addr - 64'(gap) : addr + 64'(gap);
				send_request(rsitp_pkg::OP_PREDICT, rand64(), rsitp_pkg::KIND_RETURN,
					rand64(), 1'($urandom_range(1)));
				send_request(rsitp_pkg::OP_UPDATE, rand64(), rsitp_pkg::KIND_RETURN,
					target, 1'($urandom_range(1)));
			end else if (pick < 76) begin
				// Indirect lookup, resolution, and sometimes lookup again.
				kind = ($urandom_range(1) != 0) ? rsitp_pkg::KIND_INDIRECT
				                                : rsitp_pkg::KIND_INDIRECT_CALL;
				send_request(rsitp_pkg::OP_PREDICT, addr, kind, rand64(),
					1'($urandom_range(1)));
				if (kind == rsitp_pkg::KIND_INDIRECT_CALL)
					open_calls.insert(open_calls.size(), addr);
				send_request(rsitp_pkg::OP_UPDATE, addr, kind, rand64(),
					1'($urandom_range(1)));
				if ($urandom_range(1) != 0) begin
					send_request(rsitp_pkg::OP_PREDICT, addr, rsitp_pkg::KIND_INDIRECT,
						rand64(), 1'($urandom_range(1)));
				end
			end else if (pick < 90) begin
				if ($urandom_range(2) == 0)
					send_request(rsitp_pkg::OP_PREDICT, addr, rsitp_pkg::KIND_CONDITIONAL,
						rand64(), 1'($urandom_range(1)));
				send_request(rsitp_pkg::OP_UPDATE, addr, rsitp_pkg::KIND_CONDITIONAL,
					rand64(), 1'($urandom_range(1)));
			end else begin
				op   = rsitp_pkg::op_t'($urandom_range(1));
				kind = 3'($urandom_range(7));
				send_request(op, rand64(), kind, rand64(), 1'($urandom_range(1)));
				if (op == rsitp_pkg::OP_PREDICT && (kind == rsitp_pkg::KIND_CALL ||
				    kind == rsitp_pkg::KIND_INDIRECT_CALL))
					open_calls.insert(open_calls.size(), addr);
				else if (op == rsitp_pkg::OP_UPDATE && kind == rsitp_pkg::KIND_RETURN &&
				         open_calls.size() != 0)
					void'(open_calls.pop_back());
			end
		end
	endtask

	// Request driver: reset, directed requests, random phases, verdict.
	initial begin
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		quiet_phase <= 1'b0;
		holdoff_req <= 1'b0;
		sent_items  = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			address_pool[i] = rand64();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Return update on an empty stack: the pop wraps below entry zero and
		// the distance of five from the zero entry is learned at slot zero.
		send_request(rsitp_pkg::OP_UPDATE, '0, rsitp_pkg::KIND_RETURN, 64'd5, 1'b0);
		send_request(rsitp_pkg::OP_PREDICT, '0, rsitp_pkg::KIND_RETURN, '0, 1'b0);
		// The push from the last entry wraps to entry zero; the return
		// prediction of the all-ones address wraps around 2^64.
		send_request(rsitp_pkg::OP_PREDICT, '1, rsitp_pkg::KIND_CALL, '0, 1'b0);
		send_request(rsitp_pkg::OP_PREDICT, '1, rsitp_pkg::KIND_RETURN, '1, 1'b1);
		send_request(rsitp_pkg::OP_UPDATE, '1, rsitp_pkg::KIND_RETURN, '0, 1'b1);
		// Indirect table: cold miss, learn, hit, then history moves the slot.
		send_request(rsitp_pkg::OP_PREDICT, '0, rsitp_pkg::KIND_INDIRECT, '0, 1'b0);
		send_request(rsitp_pkg::OP_UPDATE, '0, rsitp_pkg::KIND_INDIRECT, '1, 1'b1);
		send_request(rsitp_pkg::OP_PREDICT, '0, rsitp_pkg::KIND_INDIRECT, '0, 1'b0);
		send_request(rsitp_pkg::OP_UPDATE, '0, rsitp_pkg::KIND_CONDITIONAL, '0, 1'b1);
		send_request(rsitp_pkg::OP_UPDATE, '0, rsitp_pkg::KIND_CONDITIONAL, '1, 1'b0);
		send_request(rsitp_pkg::OP_PREDICT, '0, rsitp_pkg::KIND_INDIRECT, '0, 1'b0);
		// An indirect call both reads the table and pushes its address.
		send_request(rsitp_pkg::OP_PREDICT, 64'h8, rsitp_pkg::KIND_INDIRECT_CALL, '0, 1'b0);
		// Distance exactly ten is learned, eleven is not.
		send_request(rsitp_pkg::OP_UPDATE, 64'h8, rsitp_pkg::KIND_RETURN, 64'h12, 1'b0);
		send_request(rsitp_pkg::OP_PREDICT, 64'h8, rsitp_pkg::KIND_CALL, '0, 1'b0);
		send_request(rsitp_pkg::OP_PREDICT, '0, rsitp_pkg::KIND_RETURN, '0, 1'b0);
		send_request(rsitp_pkg::OP_UPDATE, '0, rsitp_pkg::KIND_RETURN, 64'h13, 1'b0);
		send_request(rsitp_pkg::OP_UPDATE, 64'h1000, rsitp_pkg::KIND_INDIRECT_CALL,
			64'h1234, 1'b0);
		send_request(rsitp_pkg::OP_PREDICT, 64'h1000, rsitp_pkg::KIND_INDIRECT_CALL,
			'0, 1'b1);
		// Kinds this block does not predict, in both operations.
		send_request(rsitp_pkg::OP_PREDICT, '1, rsitp_pkg::KIND_JUMP, '1, 1'b1);
		send_request(rsitp_pkg::OP_PREDICT, '1, rsitp_pkg::KIND_CONDITIONAL, '1, 1'b1);
		send_request(rsitp_pkg::OP_PREDICT, '1, rsitp_pkg::KIND_OTHER, '1, 1'b1);
		send_request(rsitp_pkg::OP_PREDICT, '1, KIND_UNUSED, '1, 1'b1);
		send_request(rsitp_pkg::OP_UPDATE, '1, rsitp_pkg::KIND_JUMP, '1, 1'b1);
		send_request(rsitp_pkg::OP_UPDATE, '1, rsitp_pkg::KIND_CALL, '1, 1'b1);
		send_request(rsitp_pkg::OP_UPDATE, '1, rsitp_pkg::KIND_OTHER, '1, 1'b1);
		send_request(rsitp_pkg::OP_UPDATE, '1, KIND_UNUSED, '1, 1'b1);

		run_random(RANDOM_ITEMS * 3 / 10);
		// Long result hold-off while requests keep coming, so the pipeline
		// fills and back-pressures the request channel.
		holdoff_req <= 1'b1;
		run_random(RANDOM_ITEMS / 10);
		// A stretch with no idling on either side.
		quiet_phase <= 1'b1;
		run_random(RANDOM_ITEMS / 5);
		quiet_phase <= 1'b0;
		// Request side goes silent until every result has come back.
		s_tvalid <= 1'b0;
		wait_for_drain();
		run_random(RANDOM_ITEMS * 2 / 5);

		s_tvalid <= 1'b0;
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results == 0) begin
			$display("return_stack_indirect_target_predictor regression: pass");
		end else begin
			$display("return_stack_indirect_target_predictor regression: fail");
		end
		$finish;
	end

	// Result receiver: random stalls, one long hold-off on request.
	initial begin : result_sink
		bit holdoff_taken;
		holdoff_taken = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req && !holdoff_taken) begin
				holdoff_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			m_tready <= quiet_phase || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Watchdog: counts consecutive cycles in which neither channel moves.
	initial begin : watchdog
		int stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("%0t ns: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("return_stack_indirect_target_predictor regression: fail");
		$finish;
	end

endmodule
